// File: rtl/set_assoc_cache_hit_counter_macros.svh
// assertion helpers used by the cache tag store sequencer
// each macro expects clk and arst_n in the enclosing module
`ifndef SET_ASSOC_CACHE_HIT_COUNTER_MACROS_SVH
`define SET_ASSOC_CACHE_HIT_COUNTER_MACROS_SVH

// condition that must hold at every edge out of reset
`define SACH_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// same-cycle implication
`define SACH_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SACH_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sach_pkg.sv
`default_nettype none
package sach_pkg;
	// cache geometry
	localparam int NUM_BLOCKS = 16;
	localparam int ADDR_BITS  = 8;
	// largest power of two not above the block count
	localparam int BLOCK_LOG  = $clog2(NUM_BLOCKS + 1) - 1;
	localparam int USED_BLOCKS = 1 << BLOCK_LOG;
	localparam int BLK_W      = BLOCK_LOG;
	localparam int WAY_W      = BLOCK_LOG;
	localparam int WL_W       = $clog2(BLOCK_LOG + 1);
	localparam int TAG_W      = ADDR_BITS;

	// field widths
	localparam int CFG_W      = 3;
	localparam int WAY_OUT_W  = 4;
	localparam int EVT_W      = 8;
	localparam int CNT_W      = 32;

	// counter update request from the sequencer
	typedef struct packed {
		logic upd;
		logic hit;
	} cnt_upd_t;
endpackage
`default_nettype wire

// File: rtl/sach_access_if.sv
`default_nettype none
interface sach_access_if;
	import sach_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [ADDR_BITS-1:0] access_address;

	modport source (output valid, output access_address, input ready);
	modport sink (input valid, input access_address, output ready);
endinterface
`default_nettype wire

// File: rtl/sach_result_if.sv
`default_nettype none
interface sach_result_if;
	import sach_pkg::*;
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way_used;
	logic                 evicted;
	logic [EVT_W-1:0]     evicted_tag;
	logic [CNT_W-1:0]     access_total;
	logic [CNT_W-1:0]     hit_total;

	modport source (output valid, output hit, output way_used, output evicted,
		output evicted_tag, output access_total, output hit_total, input ready);
	modport sink (input valid, input hit, input way_used, input evicted,
		input evicted_tag, input access_total, input hit_total, output ready);
endinterface
`default_nettype wire

// File: rtl/sach_ram.sv
`default_nettype none
module sach_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// File: rtl/sach_counters.sv
`default_nettype none
module sach_counters (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire sach_pkg::cnt_upd_t       stats,
	output logic      [sach_pkg::CNT_W-1:0] access_total,
	output logic      [sach_pkg::CNT_W-1:0] hit_total
);
	import sach_pkg::*;

	logic [CNT_W-1:0] access_q;
	logic [CNT_W-1:0] hits_q;

	// saturating running counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_q <= '0;
			hits_q   <= '0;
		end else if (stats.upd) begin
			if (access_q != '1) begin
				access_q <= access_q + CNT_W'(1);
			end
			if (stats.hit && hits_q != '1) begin
				hits_q <= hits_q + CNT_W'(1);
			end
		end
	end

	assign access_total = access_q;
	assign hit_total    = hits_q;
endmodule
`default_nettype wire

// File: rtl/sach_seq.sv
`default_nettype none
module sach_seq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [sach_pkg::CFG_W-1:0] ways_log,
	sach_access_if.sink                     access,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output logic                            res_hit,
	output logic [sach_pkg::WAY_OUT_W-1:0]  res_way_used,
	output logic                            res_evicted,
	output logic [sach_pkg::EVT_W-1:0]      res_evicted_tag,
	output sach_pkg::cnt_upd_t              stats
);
	import sach_pkg::*;

	`include "set_assoc_cache_hit_counter_macros.svh"

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_CMP,
		ST_WR,
		ST_DONE
	} state_t;

	state_t            state_q;
	logic [BLK_W-1:0]  set_q;
	logic [TAG_W-1:0]  tag_q;
	logic [WL_W-1:0]   sb_q;
	logic [WAY_W-1:0]  way_mask_q;
	logic [WAY_W-1:0]  way_q;
	logic [WAY_W-1:0]  vic_way_q;
	logic [WAY_W-1:0]  free_way_q;
	logic              free_found_q;
	logic [WAY_W-1:0]  res_way_q;
	logic              hit_q;
	logic              evicted_q;
	logic [TAG_W-1:0]  ev_tag_q;
	logic [USED_BLOCKS-1:0] valid_q;
	logic [WAY_W-1:0]  vp_q [USED_BLOCKS];
	logic              out_valid_q;
	logic              out_hit_q;
	logic [WAY_W-1:0]  out_way_q;
	logic              out_evicted_q;
	logic [TAG_W-1:0]  out_ev_tag_q;

	logic [WL_W-1:0]   acc_wl;
	logic [WL_W-1:0]   acc_sb;
	logic [BLK_W-1:0]  acc_set;
	logic [WAY_W-1:0]  acc_way_mask;
	logic [BLK_W-1:0]  scan_blk;
	logic              scan_valid;
	logic              scan_hit;
	logic [WAY_W-1:0]  wr_way;
	logic [BLK_W-1:0]  wr_blk;
	logic              ram_we;
	logic              ram_re;
	logic [TAG_W-1:0]  ram_rdata;
	logic              in_take;
	logic              out_load;

	// block index of way w in set s: way bits above the set bits
	function automatic logic [BLK_W-1:0] blk_of(input logic [WAY_W-1:0] w,
		input logic [BLK_W-1:0] s, input logic [WL_W-1:0] sb);
		logic [BLK_W-1:0] wide;
		wide = BLK_W'(w) << sb;
		return wide | s;
	endfunction

	// address split under the current associativity
	always_comb begin
		acc_wl       = (ways_log > CFG_W'(BLOCK_LOG)) ? WL_W'(BLOCK_LOG) : WL_W'(ways_log);
		acc_sb       = WL_W'(BLOCK_LOG) - acc_wl;
		acc_set      = access.access_address[BLK_W-1:0] & ~({BLK_W{1'b1}} << acc_sb);
		acc_way_mask = ~({WAY_W{1'b1}} << acc_wl);
	end

	// shared compare unit and write-back select
	always_comb begin
		scan_blk   = blk_of(way_q, set_q, sb_q);
		scan_valid = valid_q[scan_blk];
		scan_hit   = scan_valid && (ram_rdata == tag_q);
		wr_way     = free_found_q ? free_way_q : vic_way_q;
		wr_blk     = blk_of(wr_way, set_q, sb_q);
	end

	assign access.ready = (state_q == ST_IDLE);
	assign in_take      = access.valid && (state_q == ST_IDLE);
	assign out_load     = (state_q == ST_DONE) && (!out_valid_q || res_ready);
	assign ram_re       = (state_q == ST_RD);
	assign ram_we       = (state_q == ST_WR);

	// tag store
	sach_ram #(
		.WIDTH(TAG_W),
		.DEPTH(USED_BLOCKS)
	) u_tags (
		.clk  (clk),
		.we   (ram_we),
		.waddr(wr_blk),
		.wdata(tag_q),
		.re   (ram_re),
		.raddr(scan_blk),
		.rdata(ram_rdata)
	);

	// sequencer: walk the ways of the set, then write back on a miss
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < USED_BLOCKS; i++) begin
				vp_q[i] <= '0;
			end
		end else begin
			if (res_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						set_q        <= acc_set;
						tag_q        <= access.access_address >> acc_sb;
						sb_q         <= acc_sb;
						way_mask_q   <= acc_way_mask;
						vic_way_q    <= vp_q[acc_set] & acc_way_mask;
						way_q        <= '0;
						free_found_q <= 1'b0;
						hit_q        <= 1'b0;
						evicted_q    <= 1'b0;
						state_q      <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (way_q == vic_way_q) begin
						ev_tag_q <= ram_rdata;
					end
					if (scan_hit) begin
						hit_q     <= 1'b1;
						res_way_q <= way_q;
						state_q   <= ST_DONE;
					end else begin
						if (!scan_valid && !free_found_q) begin
							free_found_q <= 1'b1;
							free_way_q   <= way_q;
						end
						if (way_q == way_mask_q) begin
							state_q <= ST_WR;
						end else begin
							way_q   <= way_q + WAY_W'(1);
							state_q <= ST_RD;
						end
					end
				end
				ST_WR: begin
					valid_q[wr_blk] <= 1'b1;
					res_way_q       <= wr_way;
					if (!free_found_q) begin
						evicted_q   <= 1'b1;
						vp_q[set_q] <= (vic_way_q + WAY_W'(1)) & way_mask_q;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q   <= 1'b1;
						out_hit_q     <= hit_q;
						out_way_q     <= res_way_q;
						out_evicted_q <= evicted_q;
						out_ev_tag_q  <= evicted_q ? ev_tag_q : '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid       = out_valid_q;
	assign res_hit         = out_hit_q;
	assign res_way_used    = WAY_OUT_W'(out_way_q);
	assign res_evicted     = out_evicted_q;
	assign res_evicted_tag = EVT_W'(out_ev_tag_q);
	assign stats           = '{upd: out_load, hit: hit_q};

	// checks on the sequencer
	`SACH_NEXT(a_load_shows, out_load, res_valid, "result load did not raise valid")
	`SACH_IMPLY(a_hit_no_evict, res_valid, !(res_hit && res_evicted), "hit reported eviction")
	`SACH_IMPLY(a_ev_tag_zero, res_valid && !res_evicted, res_evicted_tag == '0,
		"evicted tag not zero without eviction")
	`SACH_IMPLY(a_scan_range, state_q == ST_CMP, way_q <= way_mask_q, "scan beyond way count")
	`SACH_IMPLY(a_hit_no_write, ram_we, !hit_q, "tag write after a hit")
endmodule
`default_nettype wire

// File: rtl/set_assoc_cache_hit_counter.sv
// Tag store of a 16-block cache with one-byte blocks, 8-bit addresses and
// round-robin replacement per set, with saturating access and hit counts.
// access channel: one beat carries an access_address; it is taken when
// valid and ready are both high. ready is high only while the sequencer
// is idle, so one access is in flight at a time.
// result channel: one beat per access with hit, way_used, evicted,
// evicted_tag and the running totals including that access.
// cfg_we/cfg_wdata write ways_log (log2 of the associativity, values
// above 4 act as fully associative); write it only while no access is
// in flight. Stored tags are kept across a change.
// The single read port of the tag RAM is scanned one way at a time, each
// way with a read step and then a compare step; a hit ends the scan and a
// miss adds a write-back step. ready returns after the result is loaded,
// so the next access is taken only after the current result is loaded.
// The output register lets the next access be accepted and scanned while
// a result waits; that access holds in its final step until the result
// beat is taken.
// Reset clears valid bits, victim pointers, counters, ways_log and the
// result valid flag; tag contents are left as they are.
`default_nettype none
module set_assoc_cache_hit_counter (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [sach_pkg::CFG_W-1:0] cfg_wdata,
	sach_access_if.sink                     access,
	sach_result_if.source                   result
);
	import sach_pkg::*;

	logic [CFG_W-1:0] ways_log_q;
	cnt_upd_t         stats;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ways_log_q <= '0;
		end else if (cfg_we) begin
			ways_log_q <= cfg_wdata;
		end
	end

	// lookup and fill sequencer with the tag RAM
	sach_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.ways_log       (ways_log_q),
		.access         (access),
		.res_valid      (result.valid),
		.res_ready      (result.ready),
		.res_hit        (result.hit),
		.res_way_used   (result.way_used),
		.res_evicted    (result.evicted),
		.res_evicted_tag(result.evicted_tag),
		.stats          (stats)
	);

	// running totals, stable while a result beat waits
	sach_counters u_counters (
		.clk         (clk),
		.arst_n      (arst_n),
		.stats       (stats),
		.access_total(result.access_total),
		.hit_total   (result.hit_total)
	);
endmodule
`default_nettype wire
